>>> rtl/core/xtea_pkg.sv
// Shared types, constants and the round mixing function for the XTEA core.
// No dependencies; imported by every module in rtl/core.
package xtea_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD_3 = 3'd3;

  // Item commands
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // Control that travels down the pipeline with each item
  typedef struct packed {
    logic valid;
    logic cmd;
  } stage_ctl_t;

  // Block halves carried by each stage
  typedef struct packed {
    word_t v1;
    word_t v0;
  } blk_t;

  // XTEA mixing term: ((v << 4) ^ (v >> 5)) + v
  function automatic word_t mix(input word_t v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

>>> rtl/core/xtea_key_regs.sv
// Key register file: four 32-bit key words written through the config port.
// Depends on xtea_pkg.
module xtea_key_regs
  import xtea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  word_t                wr_data,
  output key_t                 key
);

  // Decode the index and update one key word; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        KEY_WORD_0: key[0] <= wr_data;
        KEY_WORD_1: key[1] <= wr_data;
        KEY_WORD_2: key[2] <= wr_data;
        KEY_WORD_3: key[3] <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/xtea_stage.sv
// One registered half-round of XTEA, for both directions.
// Depends on xtea_pkg; instantiated 2*ROUNDS times by the top level.
module xtea_stage
  import xtea_pkg::*;
#(
  parameter int ROUNDS = 32,
  parameter int STAGE  = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  key_t       key,
  input  stage_ctl_t in_ctl,
  input  blk_t       in_blk,
  output stage_ctl_t out_ctl,
  output blk_t       out_blk
);

  localparam int ROUND_IDX = STAGE / 2;
  localparam int IS_ODD    = STAGE % 2;

  // Round sum seen by this half-round in each direction
  localparam int ENC_MULT = ROUND_IDX + IS_ODD;
  localparam int DEC_MULT = ROUNDS - ROUND_IDX - IS_ODD;
  localparam logic [63:0] ENC_PROD = 64'(ENC_MULT) * 64'(DELTA);
  localparam logic [63:0] DEC_PROD = 64'(DEC_MULT) * 64'(DELTA);
  localparam word_t ENC_SUM = ENC_PROD[WORD_W-1:0];
  localparam word_t DEC_SUM = DEC_PROD[WORD_W-1:0];

  // Encrypt updates v1 on odd stages, decrypt on even; the key index follows
  localparam logic [1:0] ENC_KSEL = (IS_ODD == 1) ? ENC_SUM[12:11] : ENC_SUM[1:0];
  localparam logic [1:0] DEC_KSEL = (IS_ODD == 1) ? DEC_SUM[1:0]   : DEC_SUM[12:11];
  localparam logic STAGE_ODD = (IS_ODD == 1);

  logic  upd_high;
  word_t src;
  word_t tgt;
  word_t sum_key;
  word_t f_term;
  word_t new_word;

  // Form the round function and add or subtract it from the target half
  always_comb begin
    upd_high = STAGE_ODD ^ in_ctl.cmd;
    src      = upd_high ? in_blk.v0 : in_blk.v1;
    tgt      = upd_high ? in_blk.v1 : in_blk.v0;
    sum_key  = (in_ctl.cmd == CMD_DECRYPT) ? DEC_SUM + key[DEC_KSEL]
                                           : ENC_SUM + key[ENC_KSEL];
    f_term   = mix(src) ^ sum_key;
    new_word = (in_ctl.cmd == CMD_DECRYPT) ? tgt - f_term : tgt + f_term;
  end

  // Advance the valid bit and command; control state clears on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
  end

  // Hold the updated halves
  always_ff @(posedge clk) begin
    out_blk.v0 <= upd_high ? in_blk.v0 : new_word;
    out_blk.v1 <= upd_high ? new_word  : in_blk.v1;
  end

endmodule

>>> rtl/core/xtea_block_cipher.sv
// XTEA block cipher core: a fully unrolled pipeline with one register stage
// per half-round (2*ROUNDS stages), fed from a four-word key register file.
// Depends on xtea_pkg, xtea_key_regs and xtea_stage.
//
// An item (command, word_low, word_high) is taken at each clock edge where
// start is high and busy is low; busy is high only during reset and the cycle
// after it, so the block takes one item every cycle. Each item's result comes
// out of the chain of half-round stages, each one add-xor-add deep, with done
// high for exactly one cycle, in the order the items went in. The receiver
// cannot stall, so nothing holds the pipeline. Key words are written through
// wr_en/wr_index/wr_data and must only change while no item is in flight.
module xtea_block_cipher
  import xtea_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [WORD_W-1:0]    wr_data,
  input  logic                 start,
  output logic                 busy,
  input  logic                 command,
  input  logic [WORD_W-1:0]    word_low,
  input  logic [WORD_W-1:0]    word_high,
  output logic                 done,
  output logic [WORD_W-1:0]    result_low,
  output logic [WORD_W-1:0]    result_high
);

  localparam int STAGES = 2 * ROUNDS;

  key_t       key;
  stage_ctl_t ctl_chain [STAGES+1];
  blk_t       blk_chain [STAGES+1];

  xtea_key_regs u_key_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .key      (key)
  );

  // Hold busy through reset and release it the cycle after
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Feed the pipeline head
  always_comb begin
    ctl_chain[0].valid = start & ~busy;
    ctl_chain[0].cmd   = command;
    blk_chain[0].v0    = word_low;
    blk_chain[0].v1    = word_high;
  end

  // Chain of half-round stages
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    xtea_stage #(
      .ROUNDS (ROUNDS),
      .STAGE  (s)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .key     (key),
      .in_ctl  (ctl_chain[s]),
      .in_blk  (blk_chain[s]),
      .out_ctl (ctl_chain[s+1]),
      .out_blk (blk_chain[s+1])
    );
  end

  // Drive the result strobe straight from the last stage
  assign done        = ctl_chain[STAGES].valid;
  assign result_low  = blk_chain[STAGES].v0;
  assign result_high = blk_chain[STAGES].v1;

endmodule

>>> verif/tb_xtea_block_cipher.sv
// Self-checking testbench for xtea_block_cipher: directed and random blocks under
// several keys, checked against an XTEA predictor held in a small scoreboard class.
// Depends on xtea_pkg and the xtea_block_cipher RTL.
module tb_xtea_block_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import xtea_pkg::*;

  localparam int ROUNDS           = 32;
  localparam int PIPE_DEPTH       = 2 * ROUNDS;
  localparam int RANDOM_BLOCKS    = 950;
  localparam int RANDOM_PHASES    = 6;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  typedef struct {
    word_t lo;
    word_t hi;
  } block_pair_t;

  // Expected-result store with its own copy of the key and an XTEA predictor
  class cipher_scoreboard;
    word_t       key_reg [KEY_WORDS];
    block_pair_t expected_q [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned deciphered;

    function new();
      foreach (key_reg[i]) key_reg[i] = '0;
      errors     = 0;
      checked    = 0;
      deciphered = 0;
    endfunction

    function void write_key(input logic [CFG_IDX_W-1:0] idx, input word_t data);
      if (idx < KEY_WORDS) key_reg[idx] = data;
    endfunction

    function word_t round_term(input word_t v);
      return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // Run all rounds forward, or backward from delta*ROUNDS
    function block_pair_t transform(input logic cmd, input word_t lo, input word_t hi);
      block_pair_t res;
      word_t v0;
      word_t v1;
      word_t sum;
      v0 = lo;
      v1 = hi;
      if (cmd == CMD_ENCRYPT) begin
        sum = '0;
        for (int r = 0; r < ROUNDS; r++) begin
          v0 += round_term(v1) ^ (sum + key_reg[sum[1:0]]);
          sum += DELTA;
          v1 += round_term(v0) ^ (sum + key_reg[sum[12:11]]);
        end
      end else begin
        sum = word_t'(DELTA * ROUNDS);
        for (int r = 0; r < ROUNDS; r++) begin
          v1 -= round_term(v0) ^ (sum + key_reg[sum[12:11]]);
          sum -= DELTA;
          v0 -= round_term(v1) ^ (sum + key_reg[sum[1:0]]);
        end
      end
      res.lo = v0;
      res.hi = v1;
      return res;
    endfunction

    function void note_block(input logic cmd, input word_t lo, input word_t hi);
      expected_q.push_back(transform(cmd, lo, hi));
      if (cmd == CMD_DECRYPT) deciphered++;
    endfunction

    function void check_result(input word_t lo, input word_t hi);
      block_pair_t exp_blk;
      if (expected_q.size() == 0) begin
        $error("unexpected result: result_low %h result_high %h", lo, hi);
        errors++;
      end else begin
        exp_blk = expected_q.pop_front();
        checked++;
        if (lo !== exp_blk.lo) begin
          $error("result_low: expected %h, got %h", exp_blk.lo, lo);
          errors++;
        end
        if (hi !== exp_blk.hi) begin
          $error("result_high: expected %h, got %h", exp_blk.hi, hi);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  word_t                wr_data = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 command = CMD_ENCRYPT;
  word_t                word_low = '0;
  word_t                word_high = '0;
  logic                 done;
  word_t                result_low;
  word_t                result_high;

  cipher_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned random_sent = 0;
  int unsigned key_settings = 0;

  xtea_block_cipher #(
    .ROUNDS(ROUNDS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .word_low   (word_low),
    .word_high  (word_high),
    .done       (done),
    .result_low (result_low),
    .result_high(result_high)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watch the ports at each edge: key writes, accepted items and results
  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) sb.write_key(wr_index, wr_data);
      if (done === 1'b1) sb.check_result(result_low, result_high);
      if (start && busy === 1'b0) sb.note_block(command, word_low, word_high);
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("xtea_block_cipher regression: fail");
      $finish;
    end
  end

  // Mostly random words, with a share of all-zero, all-one, one-hot and one-cold values
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, WORD_W - 1);
      3:       return ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      default: return $urandom;
    endcase
  endfunction

  // Present one item and hold it until the edge that takes it
  task automatic send_block(input logic cmd, input word_t lo, input word_t hi);
    start     <= 1'b1;
    command   <= cmd;
    word_low  <= lo;
    word_high <= hi;
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_cycles(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Load all four key words, optionally poking an unused index as well
  task automatic program_key(input key_t key, input bit poke_spare);
    for (int i = 0; i < KEY_WORDS; i++) begin
      wr_en    <= 1'b1;
      wr_index <= KEY_WORD_0 + CFG_IDX_W'(i);
      wr_data  <= key[i];
      @(posedge clk);
    end
    if (poke_spare) begin
      wr_en    <= 1'b1;
      wr_index <= CFG_IDX_W'($urandom_range(KEY_WORDS, CFG_IDX_TOP));
      wr_data  <= $urandom;
      @(posedge clk);
    end
    wr_en <= 1'b0;
    key_settings++;
  endtask

  // Corner blocks in both directions
  task automatic send_corner_blocks();
    send_block(CMD_ENCRYPT, '0, '0);
    send_block(CMD_DECRYPT, '0, '0);
    send_block(CMD_ENCRYPT, '1, '1);
    send_block(CMD_DECRYPT, '1, '1);
    send_block(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(CMD_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
    send_block(CMD_DECRYPT, 32'h8000_0000, 32'h0000_0001);
  endtask

  // One random item, at times followed by a round trip: its predicted result sent back inverted
  task automatic send_random_item();
    logic        cmd;
    word_t       lo;
    word_t       hi;
    block_pair_t fwd;
    cmd = 1'($urandom_range(0, 1));
    lo  = pick_word();
    hi  = pick_word();
    send_block(cmd, lo, hi);
    random_sent++;
    if ($urandom_range(0, 2) == 0) begin
      fwd = sb.transform(cmd, lo, hi);
      send_block(~cmd, fwd.lo, fwd.hi);
      random_sent++;
    end
  endtask

  initial begin
    key_t        key;
    int unsigned phase_goal;
    int unsigned burst;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Key never written: reset value of zero
    send_corner_blocks();
    drain();

    // Key all ones
    program_key({KEY_WORDS{32'hFFFF_FFFF}}, 1'b0);
    send_corner_blocks();
    drain();

    // Mixed extreme key words, plus a write to an index past the key file
    key[0] = '0;
    key[1] = '1;
    key[2] = 32'h8000_0000;
    key[3] = 32'h0000_0001;
    program_key(key, 1'b1);
    send_corner_blocks();
    drain();

    // Random keys and random traffic in bursts
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < KEY_WORDS; i++) key[i] = pick_word();
      program_key(key, 1'($urandom_range(0, 1)));
      phase_goal = (RANDOM_BLOCKS * (p + 1)) / RANDOM_PHASES;
      while (random_sent < phase_goal) begin
        burst = $urandom_range(1, 48);
        repeat (burst) send_random_item();
        case ($urandom_range(0, 15))
          0:       drain();
          1, 2, 3: ;
          default: idle_cycles($urandom_range(0, 12));
        endcase
      end
      drain();
    end

    // Let any stray result surface before judging
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    $display("checked %0d blocks (%0d deciphered) under %0d written keys and the reset key",
             sb.checked, sb.deciphered, key_settings);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("xtea_block_cipher regression: pass");
    end else begin
      $display("xtea_block_cipher regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/xtea_pkg.sv
rtl/core/xtea_key_regs.sv
rtl/core/xtea_stage.sv
rtl/core/xtea_block_cipher.sv
verif/tb_xtea_block_cipher.sv
